// ===== hdl/ising_ring_spin_update_core_macros.svh =====
// Assertion helpers shared by the spin update core.
`ifndef ISING_RING_SPIN_UPDATE_CORE_MACROS_SVH
`define ISING_RING_SPIN_UPDATE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ISR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ISR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISR_ASSERT(lbl, prop, msg)
`define ISR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/isr_pkg.sv =====
package isr_pkg;

  localparam int RING_SIZE_DEF = 64;
  localparam int SITE_W        = 6;
  localparam int RND_W         = 16;
  localparam int RANDOM_BITS   = 16;
  localparam int THR_W         = 17;
  localparam int TOT_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);
  localparam logic [RND_W-1:0] RND_MASK  = RND_W'((64'(1) << RANDOM_BITS) - 64'(1));

  localparam logic CMD_TRIAL       = 1'b0;
  localparam logic CMD_LOAD        = 1'b1;
  localparam logic MODE_GIBBS      = 1'b0;
  localparam logic MODE_METROPOLIS = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_UP_NEG   = 3'd1,
    REG_UP_ZERO  = 3'd2,
    REG_UP_POS   = 3'd3,
    REG_DN_NEG   = 3'd4,
    REG_DN_ZERO  = 3'd5,
    REG_DN_POS   = 3'd6
  } cfg_reg_t;

  // index 0: neighbor sum -2, 1: sum 0, 2: sum +2
  typedef struct packed {
    logic                  mode;
    logic [2:0][THR_W-1:0] up;
    logic [2:0][THR_W-1:0] down;
  } thr_set_t;

  typedef struct packed {
    logic signed [TOT_W-1:0] bond_sum;
    logic signed [TOT_W-1:0] magnetization;
    logic                    accepted;
    logic                    flipped;
    logic                    new_spin;
    logic [SITE_W-1:0]       site_out;
  } result_t;

endpackage

// ===== hdl/isr_cfg.sv =====
module isr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [isr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [isr_pkg::THR_W-1:0]        cfg_data,
  output isr_pkg::thr_set_t                thr
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.mode <= isr_pkg::MODE_METROPOLIS;
      thr.up   <= {3{isr_pkg::THR_RESET}};
      thr.down <= {3{isr_pkg::THR_RESET}};
    end else if (cfg_valid) begin
      case (isr_pkg::cfg_reg_t'(cfg_index))
        isr_pkg::REG_MODE:    thr.mode    <= cfg_data[0];
        isr_pkg::REG_UP_NEG:  thr.up[0]   <= cfg_data;
        isr_pkg::REG_UP_ZERO: thr.up[1]   <= cfg_data;
        isr_pkg::REG_UP_POS:  thr.up[2]   <= cfg_data;
        isr_pkg::REG_DN_NEG:  thr.down[0] <= cfg_data;
        isr_pkg::REG_DN_ZERO: thr.down[1] <= cfg_data;
        isr_pkg::REG_DN_POS:  thr.down[2] <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

// ===== hdl/isr_core.sv =====
`include "ising_ring_spin_update_core_macros.svh"

module isr_core #(
  parameter int RING_SIZE = isr_pkg::RING_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic                         command,
  input  logic [isr_pkg::SITE_W-1:0]   site_index,
  input  logic [isr_pkg::RND_W-1:0]    random_fraction,
  input  logic                         load_value,
  input  isr_pkg::thr_set_t            thr,
  output isr_pkg::result_t             result
);

  localparam int IDX_W     = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
  localparam int SITE_SPAN = 1 << isr_pkg::SITE_W;

  logic [RING_SIZE-1:0]         ring;
  logic [RING_SIZE-1:0]         ring_next;
  logic [isr_pkg::TOT_W-1:0]    mag;
  logic [isr_pkg::TOT_W-1:0]    mag_next;
  logic [isr_pkg::TOT_W-1:0]    bond;
  logic [isr_pkg::TOT_W-1:0]    bond_next;

  logic [IDX_W-1:0]             site_tab [SITE_SPAN];
  logic [IDX_W-1:0]             site_r;
  logic [IDX_W-1:0]             left_i;
  logic [IDX_W-1:0]             right_i;
  logic [1:0]                   ups;
  logic                         old_spin;
  logic                         nxt_spin;
  logic                         acc;
  logic                         flip;
  logic [isr_pkg::RND_W:0]      rnd;
  logic [isr_pkg::THR_W-1:0]    thr_sel;
  logic [isr_pkg::TOT_W-1:0]    mag_delta;
  logic [isr_pkg::TOT_W-1:0]    bond_delta;

  // site reduction modulo ring size, folded into a constant lookup
  for (genvar g = 0; g < SITE_SPAN; g++) begin : g_site_tab
    assign site_tab[g] = IDX_W'(g % RING_SIZE);
  end

  assign site_r  = site_tab[site_index];
  assign left_i  = (site_r == '0) ? IDX_W'(RING_SIZE - 1) : site_r - 1'b1;
  assign right_i = (site_r == IDX_W'(RING_SIZE - 1)) ? '0 : site_r + 1'b1;
  assign ups     = {1'b0, ring[left_i]} + {1'b0, ring[right_i]};
  assign old_spin = ring[site_r];
  assign rnd     = {1'b0, random_fraction & isr_pkg::RND_MASK};

  always_comb begin
    case (ups)
      2'd0:    thr_sel = (old_spin || thr.mode == isr_pkg::MODE_GIBBS) ? thr.up[0] : thr.down[0];
      2'd1:    thr_sel = (old_spin || thr.mode == isr_pkg::MODE_GIBBS) ? thr.up[1] : thr.down[1];
      2'd2:    thr_sel = (old_spin || thr.mode == isr_pkg::MODE_GIBBS) ? thr.up[2] : thr.down[2];
      default: thr_sel = '0;
    endcase
  end

  always_comb begin
    nxt_spin = old_spin;
    acc      = 1'b0;
    if (command == isr_pkg::CMD_LOAD) begin
      nxt_spin = load_value;
    end else if (thr.mode == isr_pkg::MODE_METROPOLIS) begin
      if (rnd < thr_sel) begin
        nxt_spin = ~old_spin;
        acc      = 1'b1;
      end
    end else begin
      nxt_spin = (rnd < thr_sel);
      acc      = 1'b1;
    end
  end

  assign flip      = nxt_spin ^ old_spin;
  assign mag_delta = nxt_spin ? isr_pkg::TOT_W'(2) : isr_pkg::TOT_W'(-2);
  // bond change is 2 * new spin * neighbor sum: zero for mixed neighbors
  assign bond_delta = (ups == 2'd1) ? '0 :
                      (((ups == 2'd2) == nxt_spin) ? isr_pkg::TOT_W'(4) : isr_pkg::TOT_W'(-4));

  always_comb begin
    ring_next = ring;
    mag_next  = mag;
    bond_next = bond;
    if (take && flip) begin
      ring_next[site_r] = nxt_spin;
      mag_next          = mag + mag_delta;
      bond_next         = bond + bond_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring <= '1;
      mag  <= isr_pkg::TOT_W'(RING_SIZE);
      bond <= isr_pkg::TOT_W'(RING_SIZE);
    end else begin
      ring <= ring_next;
      mag  <= mag_next;
      bond <= bond_next;
    end
  end

  assign result.site_out      = isr_pkg::SITE_W'(site_r);
  assign result.new_spin      = nxt_spin;
  assign result.flipped       = flip;
  assign result.accepted      = acc;
  assign result.magnetization = mag_next;
  assign result.bond_sum      = bond_next;

  `ISR_ASSERT(a_hold_no_flip, (take && !flip) |=> (mag == $past(mag) && bond == $past(bond)), "totals moved without a flip")
  `ISR_ASSERT(a_mag_step, (take && flip) |=> ((mag - $past(mag)) == 8'd2 || (mag - $past(mag)) == 8'd254), "magnetization step not 2")
  `ISR_ASSERT(a_ring_idle, !take |=> ring == $past(ring), "ring changed with no request")
  `ISR_ASSERT_ALWAYS(a_load_no_acc, (command == isr_pkg::CMD_LOAD) |-> !acc, "load reported accepted")

endmodule

// ===== hdl/isr_out_reg.sv =====
module isr_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  isr_pkg::result_t                    result,
  output logic                                s_tready,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [isr_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  isr_pkg::result_t res;

  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= result;
    end
  end

  assign m_tdata = isr_pkg::OUT_TDATA_W'(res);

endmodule

// ===== hdl/ising_ring_spin_update_core.sv =====
// One-dimensional Ising ring spin update engine. Each request either runs one
// Metropolis or heat-bath trial at a site or loads one spin, and yields exactly
// one result with the site, its new spin, flip and accept flags, and the
// running magnetization and bond sum after the change. Requests are taken one
// per clock unless a result waits on m_tready; the result is registered and
// appears in the cycle after acceptance, after combinational spin-ring reads,
// threshold compare and total update. Thresholds are probability times 65536;
// the user must write them only while the block is idle; it is not enforced.
module ising_ring_spin_update_core #(
  parameter int RING_SIZE = isr_pkg::RING_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [5:0] site_index, [21:6] random_fraction, [22] load_value, [23] zero
  input  logic [isr_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] command
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [5:0] site_out, [6] new_spin, [7] flipped, [8] accepted,
  // [16:9] magnetization, [24:17] bond_sum, [31:25] zero
  output logic [isr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [isr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [isr_pkg::THR_W-1:0]          cfg_data
);

  isr_pkg::thr_set_t thr;
  isr_pkg::result_t  result;
  logic              take;

  assign take = s_tvalid && s_tready;

  isr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  isr_core #(
    .RING_SIZE (RING_SIZE)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .command         (s_tuser),
    .site_index      (s_tdata[5:0]),
    .random_fraction (s_tdata[21:6]),
    .load_value      (s_tdata[22]),
    .thr             (thr),
    .result          (result)
  );

  isr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .result   (result),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
